>>> design/ipid_pkg.sv
// ----------------------------------------------------------------------------
// ipid_pkg: shared types and constants for the incremental pid controller
// field widths, register indexes, opcodes and the configuration bundle
// ----------------------------------------------------------------------------
`default_nettype none

package ipid_pkg;

    localparam int ERR_W      = 32;    // error sample, signed q16.16
    localparam int GAIN_W     = 32;    // gains, signed q16.16
    localparam int DRIVE_W    = 48;    // drive, signed q32.16
    localparam int BOUND_W    = 47;    // clamp magnitude, unsigned q31.16
    localparam int FRAC_W     = 16;    // fraction bits dropped after a product
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 47;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P    = 3'd0,
        CFG_GAIN_I    = 3'd1,
        CFG_GAIN_D    = 3'd2,
        CFG_ACC_MODE  = 3'd3,
        CFG_OUT_BOUND = 3'd4
    } cfg_index_t;

    typedef enum logic {
        OP_PROCESS = 1'b0,
        OP_CLEAR   = 1'b1
    } opcode_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic                     accumulate_mode;
        logic [BOUND_W-1:0]       output_bound;
    } pid_cfg_t;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

endpackage : ipid_pkg

`default_nettype wire

>>> design/ipid_datapath.sv
// ----------------------------------------------------------------------------
// ipid_datapath: one velocity-form pid step
// three fixed-point products, clamp of the stored output, sum and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module ipid_datapath (
    input  ipid_pkg::pid_cfg_t                       cfg,
    input  logic signed [ipid_pkg::ERR_W-1:0]        error_sample,
    input  logic signed [ipid_pkg::ERR_W-1:0]        prev_error,
    input  logic signed [ipid_pkg::ERR_W-1:0]        prev_prev_error,
    input  logic signed [ipid_pkg::DRIVE_W-1:0]      acc,
    output logic signed [ipid_pkg::DRIVE_W-1:0]      result
);
    import ipid_pkg::*;

    localparam int PA_W  = ERR_W + 1;          // e - e1 or e
    localparam int DA_W  = ERR_W + 2;          // e - 2 e1 + e0
    localparam int PP_W  = PA_W + GAIN_W;
    localparam int PI_W  = ERR_W + GAIN_W;
    localparam int PD_W  = DA_W + GAIN_W;
    localparam int CL_W  = BOUND_W + 2;        // signed clamp range
    localparam int SUM_W = DRIVE_W + 4;

    logic signed [PA_W-1:0]   p_operand;
    logic signed [DA_W-1:0]   d_operand;
    logic signed [PP_W-1:0]   prod_p;
    logic signed [PI_W-1:0]   prod_i;
    logic signed [PD_W-1:0]   prod_d;
    logic signed [CL_W-1:0]   bound_pos;
    logic signed [CL_W-1:0]   bound_neg;
    logic signed [CL_W-1:0]   acc_ext;
    logic signed [CL_W-1:0]   acc_clamped;
    logic signed [CL_W-1:0]   base;
    logic signed [SUM_W-1:0]  sum;

    // proportional operand: increment in accumulate mode, plain error otherwise
    always_comb
    begin
        if (cfg.accumulate_mode)
        begin
            p_operand = {error_sample[ERR_W-1], error_sample}
                      - {prev_error[ERR_W-1], prev_error};
        end
        else
        begin
            p_operand = {error_sample[ERR_W-1], error_sample};
        end
    end

    assign d_operand = {{2{error_sample[ERR_W-1]}}, error_sample}
                     - {prev_error[ERR_W-1], prev_error, 1'b0}
                     + {{2{prev_prev_error[ERR_W-1]}}, prev_prev_error};

    assign prod_p = $signed({{GAIN_W{p_operand[PA_W-1]}}, p_operand})
                  * $signed({{PA_W{cfg.gain_p[GAIN_W-1]}}, cfg.gain_p});
    assign prod_i = $signed({{GAIN_W{error_sample[ERR_W-1]}}, error_sample})
                  * $signed({{ERR_W{cfg.gain_i[GAIN_W-1]}}, cfg.gain_i});
    assign prod_d = $signed({{GAIN_W{d_operand[DA_W-1]}}, d_operand})
                  * $signed({{DA_W{cfg.gain_d[GAIN_W-1]}}, cfg.gain_d});

    // clamp of the stored output, runs alongside the multipliers
    assign bound_pos = {2'b00, cfg.output_bound};
    assign bound_neg = -bound_pos;
    assign acc_ext   = {acc[DRIVE_W-1], acc};

    always_comb
    begin
        priority if (acc_ext > bound_pos)
        begin
            acc_clamped = bound_pos;
        end
        else if (acc_ext < bound_neg)
        begin
            acc_clamped = bound_neg;
        end
        else
        begin
            acc_clamped = acc_ext;
        end
    end

    assign base = cfg.accumulate_mode ? acc_clamped : '0;

    // upper bits of each product are the floor of the q32.32 value in q32.16
    assign sum = {{(SUM_W-CL_W){base[CL_W-1]}}, base}
               + {{(SUM_W-PP_W+FRAC_W){prod_p[PP_W-1]}}, prod_p[PP_W-1:FRAC_W]}
               + {{(SUM_W-PI_W+FRAC_W){prod_i[PI_W-1]}}, prod_i[PI_W-1:FRAC_W]}
               + {{(SUM_W-PD_W+FRAC_W){prod_d[PD_W-1]}}, prod_d[PD_W-1:FRAC_W]};

    always_comb
    begin
        priority if (sum > $signed({{(SUM_W-DRIVE_W){1'b0}}, DRIVE_MAX}))
        begin
            result = DRIVE_MAX;
        end
        else if (sum < $signed({{(SUM_W-DRIVE_W){1'b1}}, DRIVE_MIN}))
        begin
            result = DRIVE_MIN;
        end
        else
        begin
            result = sum[DRIVE_W-1:0];
        end
    end

endmodule : ipid_datapath

`default_nettype wire

>>> design/incremental_pid_with_clamp.sv
// ----------------------------------------------------------------------------
// incremental_pid_with_clamp: velocity-form pid controller with clamped output
// one error beat in, one drive beat out; accumulate or direct-sum mode
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake             payload
//  -------  ---------  --------------------  ---------------------------------
//  in       input      in_valid / in_stall   opcode, error_sample
//  out      output     out_valid / out_stall drive
//  cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  an accepted beat lands in the input register; when the result register is
//  free it moves through the multiply, clamp and sum logic into the result
//  register, and one beat is taken per cycle while out_stall is low
//  the rate is set by the combinational path from the input register through
//  the three multipliers and the accumulator update into the result register
//  reset clears both valid flags, the error history and the stored output,
//  and returns the gains, mode and bound to their reset values
//  out_stall holds the result register; the input register then fills and
//  in_stall rises until the result beat is taken
//
`default_nettype none

module incremental_pid_with_clamp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // input beats
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   opcode,
    input  logic signed [ipid_pkg::ERR_W-1:0]      error_sample,
    // result beats
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [ipid_pkg::DRIVE_W-1:0]    drive,
    // configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [ipid_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ipid_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import ipid_pkg::*;

    // configuration registers
    pid_cfg_t                  cfg_reg;
    pid_cfg_t                  cfg_next;

    // input register
    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    opcode_t                   s1_opcode_reg;
    logic signed [ERR_W-1:0]   s1_error_reg;

    // controller state
    logic signed [ERR_W-1:0]   prev_error_reg;
    logic signed [ERR_W-1:0]   prev_error_next;
    logic signed [ERR_W-1:0]   prev_prev_error_reg;
    logic signed [ERR_W-1:0]   prev_prev_error_next;
    logic signed [DRIVE_W-1:0] acc_reg;
    logic signed [DRIVE_W-1:0] acc_next;

    // result register
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic signed [DRIVE_W-1:0] drive_next;

    logic                      s1_advance;
    logic                      in_accept;
    logic                      cfg_write;
    logic signed [DRIVE_W-1:0] step_result;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    // the input register moves on whenever the result register is free
    // or is being emptied in this cycle
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;

    assign s1_valid_next  = in_accept || (s1_valid_reg && !s1_advance);
    assign out_valid_next = s1_advance || (out_valid_reg && out_stall);

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    // ------------------------------------------------------------------
    // configuration decode
    // ------------------------------------------------------------------
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_GAIN_P:    cfg_next.gain_p          = cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:    cfg_next.gain_i          = cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:    cfg_next.gain_d          = cfg_data[GAIN_W-1:0];
                CFG_ACC_MODE:  cfg_next.accumulate_mode = cfg_data[0];
                CFG_OUT_BOUND: cfg_next.output_bound    = cfg_data[BOUND_W-1:0];
                default:       cfg_next = cfg_reg;   // unmapped index, ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // one pid step, fully combinational from the input register
    // ------------------------------------------------------------------
    ipid_datapath u_datapath (
        .cfg             (cfg_reg),
        .error_sample    (s1_error_reg),
        .prev_error      (prev_error_reg),
        .prev_prev_error (prev_prev_error_reg),
        .acc             (acc_reg),
        .result          (step_result)
    );

    // state and result update when the input register hands its beat on
    always_comb
    begin
        prev_error_next      = prev_error_reg;
        prev_prev_error_next = prev_prev_error_reg;
        acc_next             = acc_reg;
        drive_next           = drive_reg;
        if (s1_advance)
        begin
            unique case (s1_opcode_reg)
                OP_CLEAR:
                begin
                    // history and stored output wiped, drive reads zero
                    prev_error_next      = '0;
                    prev_prev_error_next = '0;
                    acc_next             = '0;
                    drive_next           = '0;
                end
                OP_PROCESS:
                begin
                    // errors shift in both modes, stored output only when
                    // accumulating
                    prev_error_next      = s1_error_reg;
                    prev_prev_error_next = prev_error_reg;
                    drive_next           = step_result;
                    if (cfg_reg.accumulate_mode)
                    begin
                        acc_next = step_result;
                    end
                end
                default:
                begin
                    prev_error_next = prev_error_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p          <= '0;
            cfg_reg.gain_i          <= '0;
            cfg_reg.gain_d          <= '0;
            cfg_reg.accumulate_mode <= 1'b1;
            cfg_reg.output_bound    <= '1;
            s1_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            prev_error_reg          <= '0;
            prev_prev_error_reg     <= '0;
            acc_reg                 <= '0;
        end
        else
        begin
            cfg_reg             <= cfg_next;
            s1_valid_reg        <= s1_valid_next;
            out_valid_reg       <= out_valid_next;
            prev_error_reg      <= prev_error_next;
            prev_prev_error_reg <= prev_prev_error_next;
            acc_reg             <= acc_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_opcode_reg <= opcode_t'(opcode);
            s1_error_reg  <= error_sample;
        end
        drive_reg <= drive_next;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a clear beat yields a zero drive and an empty accumulator
    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && (s1_opcode_reg == OP_CLEAR)
        |=> out_valid_reg && (drive_reg == '0) && (acc_reg == '0))
        else $error("clear beat did not zero drive and accumulator");

    // in accumulate mode the drive sent out is the value stored
    a_acc_matches_drive: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && (s1_opcode_reg == OP_PROCESS) && cfg_reg.accumulate_mode
        |=> (drive_reg == acc_reg))
        else $error("stored output differs from drive in accumulate mode");

    // direct mode leaves the stored output alone
    a_direct_keeps_acc: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && (s1_opcode_reg == OP_PROCESS) && !cfg_reg.accumulate_mode
        |=> $stable(acc_reg))
        else $error("direct mode altered the stored output");

    // the error history shifts by exactly one sample per processed beat
    a_history_shift: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && (s1_opcode_reg == OP_PROCESS)
        |=> (prev_error_reg == $past(s1_error_reg))
            && (prev_prev_error_reg == $past(prev_error_reg)))
        else $error("error history did not shift");

    // a beat held in the input register is neither lost nor overwritten
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance
        |=> s1_valid_reg && $stable(s1_error_reg) && $stable(s1_opcode_reg))
        else $error("input register changed while blocked");

endmodule : incremental_pid_with_clamp

`default_nettype wire
